// ----- design/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// tts_pkg: shared definitions for the tick task scheduler
// Sizes, command and register codes, policy codes, and the records that
// travel along the row of task cells.
// ----------------------------------------------------------------------------
package tts_pkg;

  // Table size and internal time width.
  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 24;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  // Fixed widths of the port fields.
  localparam int IDX_FIELD_W   = 4;
  localparam int TIME_FIELD_W  = 24;
  localparam int COUNT_FIELD_W = 5;
  localparam int QUANTUM_W     = 16;
  localparam int POLICY_W      = 2;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;

  // Register reset values.
  localparam logic [QUANTUM_W-1:0]     QUANTUM_RESET    = 16'd500;
  localparam logic [COUNT_FIELD_W-1:0] TASK_COUNT_RESET = 5'd1;
  localparam logic [POLICY_W-1:0]      POLICY_RESET     = 2'd0;

  // Scheduling policies.
  localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
  localparam logic [POLICY_W-1:0] POL_RR   = 2'd1;
  localparam logic [POLICY_W-1:0] POL_SJF  = 2'd2;
  localparam logic [POLICY_W-1:0] POL_SRTF = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_POLICY     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_QUANTUM    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TASK_COUNT = 2'd2;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [IDX_W-1:0]     idx_t;

  // Best candidate so far, handed from cell to cell.
  typedef struct packed {
    logic  found;
    logic  rank;
    time_t key;
    idx_t  index;
  } scan_rec_t;

  // How the cells rank themselves during a scan.
  typedef struct packed {
    logic use_remaining;
    logic use_zero;
    logic cyclic;
    idx_t start;
  } scan_ctrl_t;

  // Broadcast updates to the cells.
  typedef struct packed {
    logic  load_en;
    idx_t  load_index;
    time_t load_ready;
    time_t load_burst;
    logic  release_en;
    time_t time_now;
    logic  dec_en;
    idx_t  dec_index;
  } cell_cmd_t;

endpackage

// ----- design/tick_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// tick_task_scheduler: tick-driven task scheduler over a row of task cells
// Loads tasks by index and, on each tick, retires, releases, picks and runs
// a task under FIFO, round robin, shortest job or shortest remaining time.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start while busy is low. A load (cmd = 0) writes one
//   table entry at the transfer edge, returns no result and leaves busy low.
//   A tick (cmd = 1) raises busy while the selection record walks the row
//   of MAX_TASKS cells, one cell per cycle, after the transfer, and while
//   the FINISH state applies the choice. done, registered from FINISH, is
//   high for exactly one cycle, and the result is taken at the edge that
//   ends it; busy is already low then, so the next command may transfer at
//   that same edge. A new tick is not taken before busy falls, so ticks do
//   not overlap in the block.
//   Results cannot be held off: the receiver must take done when it comes.
//   Configuration writes use cfg_valid/cfg_ready (ready is always high);
//   the user makes them while no tick is in flight, which the block does
//   not enforce. Synchronous reset clears the released flags, time, running
//   task and counters and restores the register defaults; task entries
//   hold nothing defined until loaded.
// ----------------------------------------------------------------------------
module tick_task_scheduler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd,
  input  logic [tts_pkg::IDX_FIELD_W-1:0]     task_index,
  input  logic [tts_pkg::TIME_FIELD_W-1:0]    ready_time,
  input  logic [tts_pkg::TIME_FIELD_W-1:0]    burst_length,
  output logic                                done,
  output logic                                finished_valid,
  output logic [tts_pkg::IDX_FIELD_W-1:0]     finished_index,
  output logic                                run_valid,
  output logic [tts_pkg::IDX_FIELD_W-1:0]     run_index,
  output logic                                all_done,
  output logic [tts_pkg::TIME_FIELD_W-1:0]    tick_time,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tts_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tts_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tts_pkg::*;

  localparam int ACT_W = (IDX_W + 1 > COUNT_FIELD_W) ? IDX_W + 1 : COUNT_FIELD_W;

  localparam int            ST_W      = 2;
  localparam logic [ST_W-1:0] ST_IDLE   = 2'd0;
  localparam logic [ST_W-1:0] ST_SCAN   = 2'd1;
  localparam logic [ST_W-1:0] ST_FINISH = 2'd2;

  logic [ST_W-1:0]          state;
  idx_t                     scan_count;
  logic [POLICY_W-1:0]      policy;
  logic [QUANTUM_W-1:0]     quantum;
  logic [COUNT_FIELD_W-1:0] task_count;
  time_t                    time_now;
  logic                     running_valid;
  idx_t                     running_index;
  logic [QUANTUM_W-1:0]     slice_count;
  logic [COUNT_FIELD_W-1:0] finished_count;

  logic                 tick_accept;
  logic                 load_accept;
  logic [ACT_W-1:0]     act_count;
  logic [ACT_W-1:0]     run_ext;
  logic [ACT_W-1:0]     start_ext;
  logic [MAX_TASKS-1:0] cell_active;
  logic [MAX_TASKS-1:0] rem_zero;
  logic                 retire;
  cell_cmd_t            cell_cmd;
  scan_ctrl_t           scan_ctrl;
  scan_rec_t            chain [MAX_TASKS+1];
  scan_rec_t            tail;

  logic                 pick_valid;
  idx_t                 pick_index;
  logic                 switch_task;
  logic                 run_next;
  idx_t                 run_index_next;
  logic [QUANTUM_W-1:0] slice_base;
  logic [QUANTUM_W:0]   slice_inc;
  logic [QUANTUM_W-1:0] quantum_eff;
  logic [QUANTUM_W-1:0] slice_next;

  assign busy        = (state != ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign tick_accept = start && !busy && (cmd == CMD_TICK);
  assign load_accept = start && !busy && (cmd == CMD_LOAD);

  // Number of entries in use, and the start point of a cyclic scan.
  assign act_count = (ACT_W'(task_count) < ACT_W'(MAX_TASKS)) ?
                     ACT_W'(task_count) : ACT_W'(MAX_TASKS);
  assign run_ext   = ACT_W'(running_index);
  assign start_ext = (run_ext < act_count) ? run_ext : (act_count - ACT_W'(1));

  // The running task retires once its remaining time is zero.
  assign retire = running_valid && rem_zero[running_index];

  // Broadcast updates to the cells.
  always_comb begin
    cell_cmd.load_en    = load_accept && (32'(task_index) < 32'(MAX_TASKS));
    cell_cmd.load_index = IDX_W'(task_index);
    cell_cmd.load_ready = time_t'(ready_time);
    cell_cmd.load_burst = time_t'(burst_length);
    cell_cmd.release_en = tick_accept;
    cell_cmd.time_now   = time_now;
    cell_cmd.dec_en     = (state == ST_FINISH) && run_next;
    cell_cmd.dec_index  = run_index_next;
  end

  // Scan ranking follows the policy; round robin with a running task scans cyclically.
  always_comb begin
    scan_ctrl.use_remaining = (policy == POL_SJF) || (policy == POL_SRTF);
    scan_ctrl.use_zero      = (policy == POL_RR);
    scan_ctrl.cyclic        = (policy == POL_RR) && running_valid;
    scan_ctrl.start         = IDX_W'(start_ext);
  end

  // Row of task cells, lowest index first.
  assign chain[0] = '0;
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    assign cell_active[i] = ACT_W'(i) < act_count;
    tts_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_id  (IDX_W'(i)),
      .active   (cell_active[i]),
      .cmd      (cell_cmd),
      .ctrl     (scan_ctrl),
      .rec_in   (chain[i]),
      .rec_out  (chain[i+1]),
      .rem_zero (rem_zero[i])
    );
  end
  assign tail = chain[MAX_TASKS];

  // Task choice from the scan result.
  always_comb begin
    pick_valid = 1'b0;
    pick_index = running_index;
    unique case (policy) inside
      POL_FIFO, POL_SJF: begin
        if (running_valid) begin
          pick_valid = 1'b1;
        end else begin
          pick_valid = tail.found;
          pick_index = tail.index;
        end
      end
      POL_RR: begin
        if (!running_valid || (slice_count == '0)) begin
          if (tail.found) begin
            pick_valid = 1'b1;
            pick_index = tail.index;
          end else begin
            pick_valid = running_valid;
          end
        end else begin
          pick_valid = 1'b1;
        end
      end
      default: begin
        if (tail.found) begin
          pick_valid = 1'b1;
          pick_index = tail.index;
        end else begin
          pick_valid = running_valid;
        end
      end
    endcase
  end

  assign switch_task    = pick_valid && (!running_valid || (pick_index != running_index));
  assign run_next       = running_valid || pick_valid;
  assign run_index_next = switch_task ? pick_index : running_index;

  // Slice count restarts on a switch and wraps at the quantum.
  assign quantum_eff = (quantum == '0) ? QUANTUM_W'(1) : quantum;
  assign slice_base  = switch_task ? '0 : slice_count;
  assign slice_inc   = {1'b0, slice_base} + (QUANTUM_W+1)'(1);
  assign slice_next  = (slice_inc >= {1'b0, quantum_eff}) ? '0 : slice_inc[QUANTUM_W-1:0];

  // Sequencer: transfer, walk of the row, apply.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          scan_count <= '0;
          if (tick_accept) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_count <= scan_count + idx_t'(1);
          if (scan_count == idx_t'(MAX_TASKS - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= POLICY_RESET;
      quantum    <= QUANTUM_RESET;
      task_count <= TASK_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POLICY:     policy     <= cfg_data[POLICY_W-1:0];
        REG_QUANTUM:    quantum    <= cfg_data[QUANTUM_W-1:0];
        REG_TASK_COUNT: task_count <= cfg_data[COUNT_FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // Scheduler state: retire at the transfer, apply the choice at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now       <= '0;
      running_valid  <= 1'b0;
      running_index  <= '0;
      slice_count    <= '0;
      finished_count <= '0;
    end else if (tick_accept) begin
      if (retire) begin
        running_valid <= 1'b0;
        if (finished_count != '1) begin
          finished_count <= finished_count + COUNT_FIELD_W'(1);
        end
      end
    end else if (state == ST_FINISH) begin
      running_valid <= run_next;
      running_index <= run_index_next;
      if (time_now != '1) begin
        time_now    <= time_now + time_t'(1);
        slice_count <= slice_next;
      end else begin
        slice_count <= slice_base;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      finished_valid <= retire;
      finished_index <= retire ? IDX_FIELD_W'(running_index) : '0;
    end
    if (state == ST_FINISH) begin
      run_valid <= run_next;
      run_index <= run_next ? IDX_FIELD_W'(run_index_next) : '0;
      all_done  <= (finished_count == task_count);
      tick_time <= TIME_FIELD_W'(time_now);
    end
  end

endmodule

// ----- design/tts_cell.sv -----
// ----------------------------------------------------------------------------
// tts_cell: one task entry of the scheduler row
// Holds the ready time, remaining time and released flag of one task, and
// merges its own candidacy into the best record passed along the row.
// ----------------------------------------------------------------------------
module tts_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  tts_pkg::idx_t          cell_id,
  input  logic                   active,
  input  tts_pkg::cell_cmd_t     cmd,
  input  tts_pkg::scan_ctrl_t    ctrl,
  input  tts_pkg::scan_rec_t     rec_in,
  output tts_pkg::scan_rec_t     rec_out,
  output logic                   rem_zero
);
  import tts_pkg::*;

  time_t     ready_time;
  time_t     remaining;
  logic      released;
  logic      load_hit;
  logic      eligible;
  logic      own_rank;
  time_t     own_key;
  scan_rec_t rec_next;

  assign load_hit = cmd.load_en && (cmd.load_index == cell_id);
  assign rem_zero = (remaining == '0);

  // Task entry: written by a load, counted down while the task runs.
  always_ff @(posedge clk) begin
    if (load_hit) begin
      ready_time <= cmd.load_ready;
      remaining  <= cmd.load_burst;
    end else if (cmd.dec_en && (cmd.dec_index == cell_id) && !rem_zero) begin
      remaining <= remaining - time_t'(1);
    end
  end

  // Released flag: set when the clock reaches the ready time, cleared by a load.
  always_ff @(posedge clk) begin
    if (rst) begin
      released <= 1'b0;
    end else if (load_hit) begin
      released <= 1'b0;
    end else if (cmd.release_en && active && (ready_time == cmd.time_now)) begin
      released <= 1'b1;
    end
  end

  // Own candidacy. In a cyclic scan, entries at or before the start rank last.
  assign eligible = active && released && !rem_zero;
  assign own_rank = ctrl.cyclic && (cell_id <= ctrl.start);
  assign own_key  = ctrl.use_zero ? '0 : (ctrl.use_remaining ? remaining : ready_time);

  // Strictly better wins, so ties stay with the lower index upstream.
  always_comb begin
    rec_next = rec_in;
    if (eligible && (!rec_in.found || ({own_rank, own_key} < {rec_in.rank, rec_in.key}))) begin
      rec_next.found = 1'b1;
      rec_next.rank  = own_rank;
      rec_next.key   = own_key;
      rec_next.index = cell_id;
    end
  end

  always_ff @(posedge clk) begin
    rec_out <= rec_next;
  end

endmodule

// ----- design/tts_checker.sv -----
// ----------------------------------------------------------------------------
// tts_checker: port-level checks for the tick task scheduler
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module tts_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                cmd,
  input logic                                done,
  input logic                                finished_valid,
  input logic [tts_pkg::IDX_FIELD_W-1:0]     finished_index,
  input logic                                run_valid,
  input logic [tts_pkg::IDX_FIELD_W-1:0]     run_index
);
  import tts_pkg::*;

  // A tick transfer keeps the block busy in the following cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd == CMD_TICK) |=> busy)
    else $error("tick transfer did not raise busy");

  // A result comes at the end of a busy period, never while busy.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe outside the end of a tick");

  // Each tick gives a single result strobe.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // An absent retirement reports index zero.
  a_fin_index_zero: assert property (@(posedge clk) disable iff (rst)
    done && !finished_valid |-> finished_index == '0)
    else $error("finished index set with no retirement");

  // An idle tick reports index zero.
  a_run_index_zero: assert property (@(posedge clk) disable iff (rst)
    done && !run_valid |-> run_index == '0)
    else $error("run index set with no running task");

endmodule

bind tick_task_scheduler tts_checker u_tts_checker (.*);

// ----- dv/tick_task_scheduler_tb.sv -----
// ----------------------------------------------------------------------------
// tick_task_scheduler_tb: self-checking testbench for the tick task scheduler
// Drives load and tick commands through the start/busy handshake and checks
// every tick result against a cycle-free predictor of the scheduling rules,
// across all four policies and a range of quantum and task count settings.
// ----------------------------------------------------------------------------
import tts_pkg::*;

// One expected or observed tick outcome.
typedef struct {
  logic                     fin_v;
  logic [IDX_FIELD_W-1:0]   fin_i;
  logic                     run_v;
  logic [IDX_FIELD_W-1:0]   run_i;
  logic                     all_done;
  logic [TIME_FIELD_W-1:0]  tick_time;
} tick_result_t;

// Scheduler predictor with its own copy of the task table and registers,
// plus the queue of tick outcomes still waiting to come out of the block.
class schedule_checker;
  logic [TIME_FIELD_W-1:0]  ready_at [MAX_TASKS];
  logic [TIME_FIELD_W-1:0]  remain [MAX_TASKS];
  bit                       released [MAX_TASKS];
  logic [TIME_FIELD_W-1:0]  cur_tick;
  bit                       run_valid;
  int                       run_idx;
  int                       slice;
  int                       fin_count;
  logic [POLICY_W-1:0]      policy;
  logic [QUANTUM_W-1:0]     quantum;
  logic [COUNT_FIELD_W-1:0] task_count;
  tick_result_t             pending [$];
  int                       mismatches;
  int                       ticks_checked;

  function new();
    foreach (released[i]) released[i] = 1'b0;
    cur_tick = '0;
    run_valid = 1'b0;
    run_idx = 0;
    slice = 0;
    fin_count = 0;
    policy = POLICY_RESET;
    quantum = QUANTUM_RESET;
    task_count = TASK_COUNT_RESET;
    mismatches = 0;
    ticks_checked = 0;
  endfunction

  function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_POLICY:     policy = data[POLICY_W-1:0];
      REG_QUANTUM:    quantum = data[QUANTUM_W-1:0];
      REG_TASK_COUNT: task_count = data[COUNT_FIELD_W-1:0];
      default: ;
    endcase
  endfunction

  function bit can_run(int i, int n);
    return i < n && released[i] && remain[i] != 0;
  endfunction

  // Lowest key among runnable tasks, lower index winning ties; -1 if none.
  function int min_key(int n, bit by_remaining);
    int best;
    logic [TIME_FIELD_W-1:0] best_v, v;
    best = -1;
    best_v = '0;
    for (int i = 0; i < n; i++) begin
      if (can_run(i, n)) begin
        v = by_remaining ? remain[i] : ready_at[i];
        if (best < 0 || v < best_v) begin
          best = i;
          best_v = v;
        end
      end
    end
    return best;
  endfunction

  function int pick_next(int n);
    int first;
    int c;
    first = (run_idx < n) ? run_idx : n - 1;
    case (policy)
      POL_FIFO: return run_valid ? run_idx : min_key(n, 1'b0);
      POL_SJF:  return run_valid ? run_idx : min_key(n, 1'b1);
      POL_SRTF: return min_key(n, 1'b1);
      default: begin
        if (!run_valid) begin
          for (int i = 0; i < n; i++)
            if (can_run(i, n)) return i;
          return -1;
        end
        // At a slice boundary, rotate to the next runnable task after the
        // current one; the current task itself is reached last.
        if (slice == 0 && n > 0) begin
          for (int k = 1; k <= n; k++) begin
            c = (first + k) % n;
            if (can_run(c, n)) return c;
          end
        end
        return run_idx;
      end
    endcase
  endfunction

  // Apply one accepted command; a tick queues the outcome it must produce.
  function void note_command(logic c, logic [IDX_FIELD_W-1:0] idx,
                             logic [TIME_FIELD_W-1:0] rt, logic [TIME_FIELD_W-1:0] bl);
    tick_result_t r;
    int n;
    int q;
    int nxt;
    if (c == CMD_LOAD) begin
      ready_at[idx] = rt;
      remain[idx] = bl;
      released[idx] = 1'b0;
    end else begin
      n = (task_count < MAX_TASKS) ? task_count : MAX_TASKS;
      q = (quantum == 0) ? 1 : quantum;
      r = '{default: '0};
      // Retire the running task once its time is used up.
      if (run_valid && remain[run_idx] == 0) begin
        r.fin_v = 1'b1;
        r.fin_i = IDX_FIELD_W'(run_idx);
        run_valid = 1'b0;
        if (fin_count < 31) fin_count++;
      end
      // Release tasks whose ready time is now.
      for (int i = 0; i < n; i++)
        if (ready_at[i] == cur_tick) released[i] = 1'b1;
      // Choose and switch; a switch restarts the slice.
      nxt = pick_next(n);
      if (nxt >= 0 && (!run_valid || nxt != run_idx)) begin
        run_valid = 1'b1;
        run_idx = nxt;
        slice = 0;
      end
      // Run one tick and advance time, which holds at its maximum.
      if (run_valid) begin
        r.run_v = 1'b1;
        r.run_i = IDX_FIELD_W'(run_idx);
        if (remain[run_idx] != 0) remain[run_idx]--;
      end
      r.all_done = (fin_count == task_count);
      r.tick_time = cur_tick;
      if (cur_tick != {TIME_FIELD_W{1'b1}}) begin
        cur_tick++;
        slice++;
        if (slice >= q) slice = 0;
      end
      pending.push_back(r);
    end
  endfunction

  function void check_tick(tick_result_t got);
    tick_result_t e;
    if (pending.size() == 0) begin
      $error("tick result at time %0d with no tick outstanding", got.tick_time);
      mismatches++;
    end else begin
      e = pending.pop_front();
      ticks_checked++;
      if (got.fin_v !== e.fin_v) begin
        $error("finished_valid: expected %0d, got %0d", e.fin_v, got.fin_v);
        mismatches++;
      end
      if (got.fin_i !== e.fin_i) begin
        $error("finished_index: expected %0d, got %0d", e.fin_i, got.fin_i);
        mismatches++;
      end
      if (got.run_v !== e.run_v) begin
        $error("run_valid: expected %0d, got %0d", e.run_v, got.run_v);
        mismatches++;
      end
      if (got.run_i !== e.run_i) begin
        $error("run_index: expected %0d, got %0d", e.run_i, got.run_i);
        mismatches++;
      end
      if (got.all_done !== e.all_done) begin
        $error("all_done: expected %0d, got %0d", e.all_done, got.all_done);
        mismatches++;
      end
      if (got.tick_time !== e.tick_time) begin
        $error("tick_time: expected %0d, got %0d", e.tick_time, got.tick_time);
        mismatches++;
      end
    end
  endfunction
endclass

module tick_task_scheduler_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 12;
  localparam int MIXED_PER_PHASE = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned TIME_MAX = (32'd1 << TIME_FIELD_W) - 32'd1;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     cmd = CMD_LOAD;
  logic [IDX_FIELD_W-1:0]   task_index = '0;
  logic [TIME_FIELD_W-1:0]  ready_time = '0;
  logic [TIME_FIELD_W-1:0]  burst_length = '0;
  logic                     done;
  logic                     finished_valid;
  logic [IDX_FIELD_W-1:0]   finished_index;
  logic                     run_valid;
  logic [IDX_FIELD_W-1:0]   run_index;
  logic                     all_done;
  logic [TIME_FIELD_W-1:0]  tick_time;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  schedule_checker sched = new();
  int cycles = 0;
  int gap_pct = 0;
  int commands_sent = 0;
  int settings_used = 0;

  tick_task_scheduler uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .task_index(task_index), .ready_time(ready_time), .burst_length(burst_length),
    .done(done), .finished_valid(finished_valid), .finished_index(finished_index),
    .run_valid(run_valid), .run_index(run_index), .all_done(all_done),
    .tick_time(tick_time), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tick_task_scheduler_tb NOT OK");
      $finish;
    end
  end

  // Each done cycle carries one tick result, taken at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done)
      sched.check_tick('{finished_valid, finished_index, run_valid, run_index,
                         all_done, tick_time});
  end

  // One command transfer, with an optional random hold-off before it.
  task automatic issue(logic c, logic [IDX_FIELD_W-1:0] idx,
                       logic [TIME_FIELD_W-1:0] rt, logic [TIME_FIELD_W-1:0] bl);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    task_index <= idx;
    ready_time <= rt;
    burst_length <= bl;
    @(posedge clk);
    while (busy) @(posedge clk);
    sched.note_command(c, idx, rt, bl);
    commands_sent++;
  endtask

  task automatic load_task(int unsigned idx, int unsigned rt, int unsigned bl);
    issue(CMD_LOAD, IDX_FIELD_W'(idx), TIME_FIELD_W'(rt), TIME_FIELD_W'(bl));
  endtask

  // The unused fields of a tick carry random values.
  task automatic tick();
    issue(CMD_TICK, IDX_FIELD_W'($urandom_range(0, 15)), TIME_FIELD_W'($urandom),
          TIME_FIELD_W'($urandom));
  endtask

  // Stop issuing and let every outstanding tick come back.
  task automatic drain();
    start <= 1'b0;
    while (sched.pending.size() != 0) @(posedge clk);
    repeat (MAX_TASKS + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sched.write_register(idx, data);
  endtask

  // Register writes happen only with the block idle; upper data bits are noise.
  task automatic configure(logic [POLICY_W-1:0] pol, logic [QUANTUM_W-1:0] q,
                           logic [COUNT_FIELD_W-1:0] cnt, bit spare);
    drain();
    write_reg(REG_POLICY, (CFG_DATA_W'($urandom) & 16'hFFFC) | CFG_DATA_W'(pol));
    write_reg(REG_QUANTUM, q);
    write_reg(REG_TASK_COUNT, (CFG_DATA_W'($urandom) & 16'hFFE0) | CFG_DATA_W'(cnt));
    if (spare) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // A phase: fresh task set near the current time, then ticks mixed with
  // reloads, noise loads and the odd very long job.
  task automatic run_phase();
    int pick;
    for (int i = 0; i < MAX_TASKS; i++)
      load_task(i, sched.cur_tick + $urandom_range(0, 8), $urandom_range(0, 6));
    for (int k = 0; k < MIXED_PER_PHASE; k++) begin
      pick = $urandom_range(99);
      if (pick < 68)
        tick();
      else if (pick < 84)
        load_task($urandom_range(0, 15), sched.cur_tick + $urandom_range(0, 5),
                  $urandom_range(0, 5));
      else if (pick < 94)
        load_task($urandom_range(0, 15), $urandom, $urandom);
      else
        load_task($urandom_range(0, 15), sched.cur_tick + 1, TIME_MAX);
    end
  endtask

  initial begin
    logic [POLICY_W-1:0]      pol;
    logic [QUANTUM_W-1:0]     q;
    logic [COUNT_FIELD_W-1:0] cnt;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings (FIFO, one task). Short job to completion.
    load_task(0, 0, 2);
    tick();
    tick();
    tick();
    // Extreme field values, out of the active range; a released zero burst.
    load_task(15, TIME_MAX, TIME_MAX);
    load_task(0, sched.cur_tick + 2, 0);
    tick();
    tick();
    tick();
    // The running task is reloaded with a zero burst and retires next tick.
    load_task(0, sched.cur_tick + 1, 3);
    tick();
    tick();
    load_task(0, 0, 0);
    tick();
    tick();
    tick();
    // Maximum burst released at the current time, then cut short.
    load_task(0, sched.cur_tick, TIME_MAX);
    tick();
    tick();
    load_task(0, 0, 0);
    tick();
    tick();

    // Random phases: fixed extremes first, then random settings, and a
    // count beyond the table last so that all_done can rise again.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:  begin pol = POL_FIFO; q = 500;   cnt = 16; end
        1:  begin pol = POL_RR;   q = 1;     cnt = 16; end
        2:  begin pol = POL_RR;   q = 0;     cnt = 5;  end
        3:  begin pol = POL_RR;   q = 16'hFFFF; cnt = 3; end
        4:  begin pol = POL_SJF;  q = 3;     cnt = 16; end
        5:  begin pol = POL_SRTF; q = 7;     cnt = 1;  end
        6:  begin pol = POL_RR;   q = 2;     cnt = 20; end
        7:  begin pol = POL_SRTF; q = 16'hFFFF; cnt = 12; end
        11: begin pol = POL_RR;   q = 3;     cnt = 31; end
        default: begin
          pol = POLICY_W'($urandom_range(0, 3));
          q = QUANTUM_W'($urandom_range(1, 8));
          cnt = COUNT_FIELD_W'($urandom_range(1, 16));
        end
      endcase
      gap_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 49 : 15);
      configure(pol, q, cnt, p == 3);
      run_phase();
    end

    drain();
    if (sched.pending.size() != 0) sched.mismatches++;
    $display("Sent %0d commands; %0d tick results checked over %0d register settings.",
             commands_sent, sched.ticks_checked, settings_used);
    $display("Policies FIFO, round robin, shortest job and shortest remaining were all used.");
    if (sched.mismatches == 0)
      $display("tick_task_scheduler_tb OK");
    else
      $display("tick_task_scheduler_tb NOT OK");
    $finish;
  end

endmodule
